// ===== sv/pssh_key_id_extractor_assert.svh =====
// assertion macros used by the key id extractor front stage (pkx_front)
`ifndef PSSH_KEY_ID_EXTRACTOR_ASSERT_SVH
`define PSSH_KEY_ID_EXTRACTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PKX_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PKX_ASSERT_NX(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pkx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pkx_pkg;

	localparam int KEY_BYTES       = 16;
	localparam int SYSTEM_ID_BYTES = 16;

	localparam int HDR_W  = 6;
	localparam int BIK_W  = 5;
	localparam int MP_W   = 3;
	localparam int KEYS_W = 32;

	localparam logic [HDR_W-1:0] VERSION_START = HDR_W'(8);
	localparam logic [HDR_W-1:0] VERSION_END   = HDR_W'(12);
	localparam logic [HDR_W-1:0] VERSION_LAST  = HDR_W'(11);
	localparam logic [HDR_W-1:0] COUNT_START   = HDR_W'(12 + SYSTEM_ID_BYTES);
	localparam logic [HDR_W-1:0] KEYS_START    = HDR_W'(16 + SYSTEM_ID_BYTES);
	localparam logic [BIK_W-1:0] KEY_LAST      = BIK_W'(KEY_BYTES - 1);
	localparam logic [MP_W-1:0]  MATCH_LAST    = MP_W'(3);

	localparam logic [7:0] CH_K      = 8'h6b;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] KIDS_WORD [4] = '{8'h6b, 8'h69, 8'h64, 8'h73};

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_SEEK,
		PH_LIST,
		PH_QUOTE,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] key_byte;
		logic       byte_valid;
		logic       key_end;
	} result_t;

	// bit 6 set: not a base64 character
	function automatic logic [6:0] b64_decode(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c inside {[8'h41:8'h5a]}) begin
			d = c - 8'h41;
			return {1'b0, d[5:0]};
		end else if (c inside {[8'h61:8'h7a]}) begin
			d = c - 8'h61 + 8'd26;
			return {1'b0, d[5:0]};
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30 + 8'd52;
			return {1'b0, d[5:0]};
		end else if (c inside {8'h2b, 8'h2d}) begin
			return 7'd62;
		end else if (c inside {8'h2f, 8'h5f}) begin
			return 7'd63;
		end
		return 7'h40;
	endfunction

endpackage
`default_nettype wire

// ===== sv/pssh_key_id_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Key id extractor for a content-protection (pssh) box. The box streams in one
// request per byte, with final_byte set on its last byte; after that byte the
// block is back at its start for the next box. Bytes 8..11 select the mode: all
// zero means version 0, where the "kids" list is found and each quoted base64
// string is decoded into key id bytes, with a key_end request (byte_valid low)
// at each closing quote; anything else means version 1, where a big-endian key
// count follows the system id and that many 16-byte key ids are passed through,
// key_end marking the last byte of each. Every input byte yields zero or one
// result, and a new byte can be taken every cycle while the queue has room. The
// front stage updates all parse state in the cycle of acceptance and writes any
// result into a two-entry queue whose head drives the output ports, so a result
// is registered in the queue and reaches the outputs once those ahead of it are
// popped. Input is held off in every cycle the queue is full; with a result per
// byte a stalled output fills it and holds the input off in turn.
module pssh_key_id_extractor (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      key_byte,
	output logic            byte_valid,
	output logic            key_end
);
	import pkx_pkg::*;

	logic    take;
	logic    push;
	logic    q_full;
	result_t front_res;
	result_t head;

	// accept while the queue has room for the one result a byte may cause
	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	// front: header tracking, kids/list scan, base64 decode, version 1 counter
	pkx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.res        (front_res),
		.push       (push)
	);

	// back: queue head is the output register
	pkx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (front_res),
		.full     (q_full),
		.rd_valid (out_valid),
		.pop      (out_ready),
		.rd_data  (head)
	);

	assign key_byte   = head.key_byte;
	assign byte_valid = head.byte_valid;
	assign key_end    = head.key_end;

endmodule
`default_nettype wire

// ===== sv/pkx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "pssh_key_id_extractor_assert.svh"
module pkx_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      data_byte,
	input  wire logic            final_byte,
	output pkx_pkg::result_t     res,
	output logic                 push
);
	import pkx_pkg::*;

	logic [HDR_W-1:0]  hdr_q, hdr_d;
	logic              ver_q, ver_d;
	logic [MP_W-1:0]   mp_q, mp_d;
	phase_t            phase_q, phase_d;
	logic [1:0]        grp_q, grp_d;
	logic [5:0]        carry_q, carry_d;
	logic [KEYS_W-1:0] keys_q, keys_d;
	logic [BIK_W-1:0]  bik_q, bik_d;
	logic              emit0;
	logic [6:0]        b64;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= '0;
			ver_q   <= 1'b0;
			mp_q    <= '0;
			grp_q   <= '0;
			carry_q <= '0;
			keys_q  <= '0;
			bik_q   <= '0;
		end else begin
			hdr_q   <= hdr_d;
			ver_q   <= ver_d;
			mp_q    <= mp_d;
			grp_q   <= grp_d;
			carry_q <= carry_d;
			keys_q  <= keys_d;
			bik_q   <= bik_d;
		end
	end

	always_comb begin
		hdr_d   = hdr_q;
		ver_d   = ver_q;
		mp_d    = mp_q;
		phase_d = phase_q;
		grp_d   = grp_q;
		carry_d = carry_q;
		keys_d  = keys_q;
		bik_d   = bik_q;
		res     = '0;
		push    = 1'b0;
		emit0   = 1'b0;
		b64     = b64_decode(data_byte);
		if (take) begin
			if (hdr_q >= VERSION_START && hdr_q < VERSION_END && data_byte != 8'h00) begin
				ver_d = 1'b1;
			end
			emit0 = (hdr_q >= VERSION_LAST) && !ver_d;

			case (phase_q)
				PH_SEARCH: begin
					if (data_byte == KIDS_WORD[mp_q[1:0]]) begin
						if (mp_q >= MATCH_LAST) begin
							mp_d    = '0;
							phase_d = PH_SEEK;
						end else begin
							mp_d = mp_q + MP_W'(1);
						end
					end else begin
						mp_d = (data_byte == CH_K) ? MP_W'(1) : '0;
					end
				end
				PH_SEEK: begin
					if (data_byte == CH_LBRACK) phase_d = PH_LIST;
				end
				PH_LIST: begin
					if (data_byte == CH_RBRACK) begin
						phase_d = PH_DONE;
					end else if (data_byte == CH_QUOTE) begin
						phase_d = PH_QUOTE;
						grp_d   = '0;
						carry_d = '0;
					end
				end
				PH_QUOTE: begin
					if (data_byte == CH_RBRACK) begin
						phase_d = PH_DONE;
					end else if (data_byte == CH_QUOTE) begin
						phase_d = PH_LIST;
						if (emit0) begin
							res.key_end = 1'b1;
							push        = 1'b1;
						end
					end else if (!b64[6]) begin
						case (grp_q)
							2'd0: begin
								carry_d = b64[5:0];
							end
							2'd1: begin
								res.key_byte = {carry_q[5:0], b64[5:4]};
								carry_d      = {2'b00, b64[3:0]};
							end
							2'd2: begin
								res.key_byte = {carry_q[3:0], b64[5:2]};
								carry_d      = {4'b0000, b64[1:0]};
							end
							default: begin
								res.key_byte = {carry_q[1:0], b64[5:0]};
								carry_d      = '0;
							end
						endcase
						if (grp_q != 2'd0 && emit0) begin
							res.byte_valid = 1'b1;
							push           = 1'b1;
						end else begin
							res.key_byte = '0;
						end
						grp_d = grp_q + 2'd1;
					end
				end
				default: begin
				end
			endcase

			// version 1: count word, then fixed-size key ids
			if (ver_d && hdr_q >= COUNT_START) begin
				if (hdr_q < KEYS_START) begin
					keys_d = {keys_q[KEYS_W-9:0], data_byte};
				end else if (keys_q != '0) begin
					res.key_byte   = data_byte;
					res.byte_valid = 1'b1;
					res.key_end    = 1'b0;
					push           = 1'b1;
					if (bik_q >= KEY_LAST) begin
						res.key_end = 1'b1;
						bik_d       = '0;
						keys_d      = keys_q - KEYS_W'(1);
					end else begin
						bik_d = bik_q + BIK_W'(1);
					end
				end
			end

			if (hdr_q < KEYS_START) hdr_d = hdr_q + HDR_W'(1);

			if (final_byte) begin
				hdr_d   = '0;
				ver_d   = 1'b0;
				mp_d    = '0;
				phase_d = PH_SEARCH;
				grp_d   = '0;
				carry_d = '0;
				keys_d  = '0;
				bik_d   = '0;
			end
		end
	end

	`PKX_ASSERT(a_res_nonempty, push, res.byte_valid || res.key_end, "empty result pushed")
	`PKX_ASSERT(a_hdr_bound, 1'b1, hdr_q <= KEYS_START, "header position overran")
	`PKX_ASSERT_NX(a_final_clears, take && final_byte, hdr_q == '0 && phase_q == PH_SEARCH && keys_q == '0, "state not cleared after final byte")

endmodule
`default_nettype wire

// ===== sv/pkx_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pkx_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire pkx_pkg::result_t wr_data,
	output logic                  full,
	output logic                  rd_valid,
	input  wire logic             pop,
	output pkx_pkg::result_t      rd_data
);
	import pkx_pkg::*;

	result_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push, do_pop;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire
